/* rtl/spiq_pkg.sv */
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types and constants of the sorted-insertion priority queue.
// ----------------------------------------------------------------------------
package spiq_pkg;

	localparam int DEPTH_DEF    = 8;
	localparam int TAG_BITS_DEF = 16;
	localparam int PRIO_BITS    = 3;
	localparam int OCC_BITS     = 4;
	localparam int STATUS_BITS  = 2;

	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                 enq;
		logic                 deq;
		logic [PRIO_BITS-1:0] prio;
	} cell_ctl_t;

endpackage

/* rtl/spiq_cell.sv */
// ----------------------------------------------------------------------------
// spiq_cell
// One slot of the sorted chain: keeps its entry, takes its left neighbor's,
// takes the new entry on an enqueue, or takes its right neighbor's on a dequeue.
// ----------------------------------------------------------------------------
module spiq_cell #(
	parameter int TAG_BITS = spiq_pkg::TAG_BITS_DEF
) (
	input  logic                           clk,
	input  spiq_pkg::cell_ctl_t            ctl,
	input  logic [TAG_BITS-1:0]            new_tag,
	input  logic                           occ_self,
	input  logic                           occ_left,
	input  logic [spiq_pkg::PRIO_BITS-1:0] left_prio,
	input  logic [TAG_BITS-1:0]            left_tag,
	input  logic [spiq_pkg::PRIO_BITS-1:0] right_prio,
	input  logic [TAG_BITS-1:0]            right_tag,
	output logic [spiq_pkg::PRIO_BITS-1:0] prio,
	output logic [TAG_BITS-1:0]            tag
);

	logic [spiq_pkg::PRIO_BITS-1:0] prio_q;
	logic [TAG_BITS-1:0]            tag_q;
	logic                           keep;
	logic                           left_moves;

	assign keep       = occ_self && (prio_q <= ctl.prio);
	assign left_moves = occ_left && (left_prio > ctl.prio);

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			prio_q <= right_prio;
			tag_q  <= right_tag;
		end else if (ctl.enq && !keep) begin
			if (left_moves) begin
				prio_q <= left_prio;
				tag_q  <= left_tag;
			end else begin
				prio_q <= ctl.prio;
				tag_q  <= new_tag;
			end
		end
	end

	assign prio = prio_q;
	assign tag  = tag_q;

endmodule

/* rtl/sorted_insert_priority_queue.sv */
// The queue holds up to DEPTH entries of a 3-bit priority and a tag, sorted so
// that the lowest priority value leaves first and equal priorities leave in
// arrival order. Every input item (tuser 0 enqueue, 1 dequeue) yields exactly
// one result item with a status, the dequeued entry and the occupancy after
// the operation. The whole row of cells shifts in parallel on the accepting
// edge, so a new item can be accepted in every cycle while the registered
// result is taken, and the result appears in the cycle after acceptance.
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Top level: stream handshake, fill count, result register and the cell row.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
	parameter int DEPTH    = spiq_pkg::DEPTH_DEF,
	parameter int TAG_BITS = spiq_pkg::TAG_BITS_DEF,
	localparam int IN_BITS  = ((spiq_pkg::PRIO_BITS + TAG_BITS + 7) / 8) * 8,
	localparam int OUT_BITS =
		((spiq_pkg::PRIO_BITS + TAG_BITS + spiq_pkg::OCC_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IN_BITS-1:0]               s_tdata,  // prio_in, tag_in
	input  logic                             s_tuser,  // func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_BITS-1:0]              m_tdata,  // prio_out, tag_out, occupancy
	output logic [spiq_pkg::STATUS_BITS-1:0] m_tuser   // status
);

	localparam int PB       = spiq_pkg::PRIO_BITS;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic                  accept;
	logic [PB-1:0]         in_prio;
	logic [TAG_BITS-1:0]   in_tag;
	logic                  full;
	logic                  empty;
	logic                  enq_ok;
	logic                  deq_ok;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   count_nxt;
	spiq_pkg::status_t     status_nxt;
	spiq_pkg::cell_ctl_t   ctl;

	logic [PB-1:0]         cell_prio [DEPTH];
	logic [TAG_BITS-1:0]   cell_tag  [DEPTH];
	logic [DEPTH-1:0]      occ;

	logic                              out_valid_q;
	spiq_pkg::status_t                 status_q;
	logic [PB-1:0]                     prio_q;
	logic [TAG_BITS-1:0]               tag_q;
	logic [spiq_pkg::OCC_BITS-1:0]     occ_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign in_prio  = s_tdata[PB-1:0];
	assign in_tag   = s_tdata[PB+TAG_BITS-1:PB];

	assign full   = (count_q == CNT_BITS'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_ok = accept && (s_tuser == spiq_pkg::FUNC_ENQ) && !full;
	assign deq_ok = accept && (s_tuser == spiq_pkg::FUNC_DEQ) && !empty;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = spiq_pkg::ST_OK;
		if (enq_ok) begin
			count_nxt = count_q + 1'b1;
		end else if (deq_ok) begin
			count_nxt = count_q - 1'b1;
		end else if (s_tuser == spiq_pkg::FUNC_ENQ) begin
			status_nxt = spiq_pkg::ST_FULL;
		end else begin
			status_nxt = spiq_pkg::ST_EMPTY;
		end
	end

	assign ctl.enq  = enq_ok;
	assign ctl.deq  = deq_ok;
	assign ctl.prio = in_prio;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CNT_BITS'(i));

		spiq_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_tag   (in_tag),
			.occ_self  (occ[i]),
			.occ_left  ((i == 0) ? 1'b0 : occ[(i == 0) ? 0 : i - 1]),
			.left_prio (cell_prio[(i == 0) ? 0 : i - 1]),
			.left_tag  (cell_tag[(i == 0) ? 0 : i - 1]),
			.right_prio((i == DEPTH - 1) ? '0 : cell_prio[(i == DEPTH - 1) ? i : i + 1]),
			.right_tag ((i == DEPTH - 1) ? '0 : cell_tag[(i == DEPTH - 1) ? i : i + 1]),
			.prio      (cell_prio[i]),
			.tag       (cell_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			prio_q   <= deq_ok ? cell_prio[0] : '0;
			tag_q    <= deq_ok ? cell_tag[0] : '0;
			occ_q    <= spiq_pkg::OCC_BITS'(count_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_BITS'({occ_q, tag_q, prio_q});

endmodule

/* rtl/spiq_checker.sv */
// ----------------------------------------------------------------------------
// spiq_checker
// Port-level checks of the priority queue result stream, bound to the top.
// ----------------------------------------------------------------------------
module spiq_checker #(
	parameter int DEPTH    = spiq_pkg::DEPTH_DEF,
	parameter int TAG_BITS = spiq_pkg::TAG_BITS_DEF,
	parameter int OUT_BITS = 24
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [OUT_BITS-1:0]              m_tdata,
	input logic [spiq_pkg::STATUS_BITS-1:0] m_tuser
);

	localparam int PB = spiq_pkg::PRIO_BITS;
	localparam int OB = spiq_pkg::OCC_BITS;

	logic [PB+TAG_BITS-1:0] entry;
	logic [OB-1:0]          occupancy;

	assign entry     = m_tdata[PB+TAG_BITS-1:0];
	assign occupancy = m_tdata[PB+TAG_BITS+OB-1:PB+TAG_BITS];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == spiq_pkg::ST_OK) || (m_tuser == spiq_pkg::ST_FULL) ||
			(m_tuser == spiq_pkg::ST_EMPTY))
		else $error("Result status is not a defined code.");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != spiq_pkg::ST_OK) |-> (entry == '0))
		else $error("A refused operation returned an entry.");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spiq_pkg::ST_EMPTY) |-> (occupancy == '0))
		else $error("Empty status with nonzero occupancy.");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == spiq_pkg::ST_FULL) |-> (occupancy == OB'(DEPTH)))
		else $error("Full status with occupancy below capacity.");

endmodule

bind sorted_insert_priority_queue spiq_checker #(
	.DEPTH   (DEPTH),
	.TAG_BITS(TAG_BITS),
	.OUT_BITS(OUT_BITS)
) u_spiq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sorted-insertion priority queue. A directed table covers
// the empty and full refusals, the priority and tag extremes and the arrival
// order of equal priorities. Random enqueue and dequeue mixes follow, with
// random idle bursts on both sides and one long output stall. Every result
// item is checked against its table row or a behavioral copy of the queue.
// ----------------------------------------------------------------------------
module tb_top;

	typedef spiq_pkg::func_t   func_t;
	typedef spiq_pkg::status_t status_t;

	localparam func_t   FUNC_ENQ = spiq_pkg::FUNC_ENQ;
	localparam func_t   FUNC_DEQ = spiq_pkg::FUNC_DEQ;
	localparam status_t ST_OK    = spiq_pkg::ST_OK;
	localparam status_t ST_FULL  = spiq_pkg::ST_FULL;
	localparam status_t ST_EMPTY = spiq_pkg::ST_EMPTY;

	localparam int QDEPTH       = spiq_pkg::DEPTH_DEF;
	localparam int IN_W         = 24;
	localparam int OUT_W        = 24;
	localparam int RANDOM_ITEMS = 1830;
	localparam int PLAN_ROWS    = 20;

	typedef struct packed {
		status_t    status;
		logic [2:0]  prio;
		logic [15:0] tag;
		logic [3:0]  occ;
	} queue_result_t;

	typedef struct packed {
		func_t         func;
		logic [2:0]    prio;
		logic [15:0]   tag;
		logic          typed;
		queue_result_t want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;

	logic [2:0]    held_prio [QDEPTH];
	logic [15:0]   held_tag  [QDEPTH];
	int            held_count = 0;
	queue_result_t result_q [$];
	stim_row_t     plan [PLAN_ROWS];
	int unsigned   accepted_items = 0;
	int unsigned   mismatches = 0;
	bit            relaxed = 1'b0;
	bit            held_off = 1'b0;

	sorted_insert_priority_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic queue_result_t queue_step(func_t f, logic [2:0] p, logic [15:0] t);
		queue_result_t r;
		int pos;
		int k;
		r = '{ST_OK, 3'd0, 16'd0, 4'd0};
		if (f == FUNC_ENQ) begin
			if (held_count >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = held_count;
				while (pos > 0 && held_prio[pos-1] > p) begin
					held_prio[pos] = held_prio[pos-1];
					held_tag[pos]  = held_tag[pos-1];
					pos--;
				end
				held_prio[pos] = p;
				held_tag[pos]  = t;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.prio = held_prio[0];
			r.tag  = held_tag[0];
			for (k = 1; k < held_count; k++) begin
				held_prio[k-1] = held_prio[k];
				held_tag[k-1]  = held_tag[k];
			end
			held_count--;
		end
		r.occ = 4'(held_count);
		return r;
	endfunction

	task automatic offer(input func_t f, input logic [2:0] p, input logic [15:0] t);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {{(IN_W-19){1'b0}}, t, p};
		do @(posedge clk); while (!s_tready);
		accepted_items++;
	endtask

	task automatic maybe_idle();
		if (!relaxed && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result item tuser %h tdata %h",
					m_tuser, m_tdata));
			end else begin
				want = result_q.pop_front();
				if (m_tuser !== want.status || m_tdata[2:0] !== want.prio ||
					m_tdata[18:3] !== want.tag || m_tdata[22:19] !== want.occ)
					flag_mismatch($sformatf(
						"status %0d/%0d prio %0d/%0d tag %h/%h occupancy %0d/%0d (exp/got)",
						want.status, m_tuser, want.prio, m_tdata[2:0],
						want.tag, m_tdata[18:3], want.occ, m_tdata[22:19]));
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && accepted_items >= 700) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (48) @(posedge clk);
			end else if (!relaxed && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("sorted_insert_priority_queue verification failed");
		$finish;
	end

	initial begin
		queue_result_t r;
		func_t         f;
		int            i;
		int            phase_left;
		int            enq_pct;
		s_tvalid = 1'b0;
		s_tuser  = FUNC_ENQ;
		s_tdata  = '0;
		arst_n   = 1'b0;
		phase_left = 0;
		enq_pct    = 50;
		plan = '{
			'{FUNC_DEQ, 3'd7, 16'hFFFF, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000, 4'd0}},
			'{FUNC_ENQ, 3'd7, 16'hFFFF, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd1}},
			'{FUNC_ENQ, 3'd0, 16'h0000, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd2}},
			'{FUNC_ENQ, 3'd3, 16'h1234, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd3}},
			'{FUNC_ENQ, 3'd3, 16'h5678, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd4}},
			'{FUNC_ENQ, 3'd0, 16'hAAAA, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd5}},
			'{FUNC_ENQ, 3'd5, 16'h5555, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd6}},
			'{FUNC_ENQ, 3'd7, 16'h0001, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd7}},
			'{FUNC_ENQ, 3'd1, 16'h8000, 1'b1, '{ST_OK,    3'd0, 16'h0000, 4'd8}},
			'{FUNC_ENQ, 3'd2, 16'hBEEF, 1'b1, '{ST_FULL,  3'd0, 16'h0000, 4'd8}},
			'{FUNC_DEQ, 3'd0, 16'h0000, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd7, 16'hFFFF, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd0, 16'h0000, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd7, 16'hFFFF, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd0, 16'h0000, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd7, 16'hFFFF, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd0, 16'h0000, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd7, 16'hFFFF, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}},
			'{FUNC_DEQ, 3'd0, 16'h0000, 1'b1, '{ST_EMPTY, 3'd0, 16'h0000, 4'd0}},
			'{FUNC_ENQ, 3'd4, 16'h0F0F, 1'b0, '{ST_OK,    3'd0, 16'h0000, 4'd0}}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++) begin
			offer(plan[i].func, plan[i].prio, plan[i].tag);
			r = queue_step(plan[i].func, plan[i].prio, plan[i].tag);
			result_q.push_back(plan[i].typed ? plan[i].want : r);
			maybe_idle();
		end

		// Phases lean toward enqueue or dequeue so that full and empty come often.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - 200)
				relaxed = 1'b1;
			if (phase_left == 0) begin
				phase_left = $urandom_range(8, 40);
				case ($urandom_range(0, 3))
					0: enq_pct = 15;
					1: enq_pct = 50;
					2: enq_pct = 85;
					default: enq_pct = 95;
				endcase
			end
			phase_left--;
			f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
			r.prio = 3'($urandom_range(0, 7));
			r.tag  = 16'($urandom_range(0, 65535));
			offer(f, r.prio, r.tag);
			result_q.push_back(queue_step(f, r.prio, r.tag));
			maybe_idle();
		end
		s_tvalid <= 1'b0;

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_insert_priority_queue verification clean");
		else
			$display("sorted_insert_priority_queue verification failed");
		$finish;
	end

endmodule

/* sorted_insert_priority_queue.f */
rtl/spiq_pkg.sv
rtl/spiq_cell.sv
rtl/sorted_insert_priority_queue.sv
rtl/spiq_checker.sv
tb/tb_top.sv
